// ===== hdl/pvp_pkg.sv =====
package pvp_pkg;

	localparam int FRAC_BITS = 8;

	localparam int CW   = 24;
	localparam int FSW  = 16;
	localparam int CENW = 10;
	localparam int OW   = 16;
	localparam int IDXW = 2;

	localparam int DW    = CW + 1;
	localparam int DUW   = CW;
	localparam int DENW  = DUW + FRAC_BITS;
	localparam int PW    = CW + FSW;
	localparam int CDW   = CENW + DENW;
	localparam int NMW   = ((CDW > PW) ? CDW : PW) + 1;
	localparam int NW    = NMW + 1;
	localparam int QW    = OW;
	localparam int QN    = QW + 1;
	localparam int DSW   = DENW + QW;
	localparam int NCELL = QN;

	localparam logic [DUW-1:0] DEPTH_ONE = DUW'(1) << FRAC_BITS;

	localparam logic [CW-1:0]   CAMERA_Z_RST    = CW'(-25600);
	localparam logic [FSW-1:0]  FOCAL_SCALE_RST = FSW'(30720);
	localparam logic [CENW-1:0] CENTER_X_RST    = CENW'(140);
	localparam logic [CENW-1:0] CENTER_Y_RST    = CENW'(120);

	typedef enum logic [IDXW-1:0] {
		REG_CAMERA_Z    = 2'd0,
		REG_FOCAL_SCALE = 2'd1,
		REG_CENTER_X    = 2'd2,
		REG_CENTER_Y    = 2'd3
	} pvp_reg_t;

	typedef struct packed {
		logic [CW-1:0]   camera_z;
		logic [FSW-1:0]  focal_scale;
		logic [CENW-1:0] center_x;
		logic [CENW-1:0] center_y;
	} pvp_cfg_t;

	// one divider step for both coordinates, sharing the shifted divisor
	typedef struct packed {
		logic            neg_x;
		logic            neg_y;
		logic            clamped;
		logic [NMW-1:0]  rem_x;
		logic [NMW-1:0]  rem_y;
		logic [DSW-1:0]  dsh;
		logic [QN-1:0]   q_x;
		logic [QN-1:0]   q_y;
	} pvp_cell_t;

endpackage

// ===== hdl/perspective_vertex_project.sv =====
// perspective projection of one vertex per request
// input channel: in_valid/in_ready with vertex_x, vertex_y, vertex_z, signed,
//   FRAC_BITS fraction bits
// output channel: out_valid/out_ready with screen_x, screen_y (signed 16-bit,
//   truncated toward zero and clipped), depth_clamped and saturated
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready,
//   write only while no request is in flight
//   index 0 camera_z, 1 focal_scale, 2 center_x, 3 center_y
// structure: 4 front stages, 17 divider cells and the output register
// throughput: one request per cycle while the receiver does not stall; every divider
//   cell holds one request and resolves one quotient bit, the first cell detecting overflow
// reset clears all stage valids and loads camera_z -100.0, focal_scale 120.0,
//   center 140/120
// when the receiver stalls, the held result stays on the outputs and empty
//   stages keep filling, so in_ready drops only once the whole chain is full
module perspective_vertex_project import pvp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDXW-1:0]        cfg_index,
	input  logic [CW-1:0]          cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [CW-1:0]   vertex_x,
	input  logic signed [CW-1:0]   vertex_y,
	input  logic signed [CW-1:0]   vertex_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [OW-1:0]   screen_x,
	output logic signed [OW-1:0]   screen_y,
	output logic                   depth_clamped,
	output logic                   saturated
);

	pvp_cfg_t  cfg_q;

	pvp_cell_t chain_d [NCELL+1];
	logic      chain_v [NCELL+1];
	logic      chain_r [NCELL+1];

	pvp_cell_t      last;
	logic [OW:0]    res_x, res_y;

	logic           out_valid_q;
	logic [OW-1:0]  screen_x_q, screen_y_q;
	logic           clamped_q, sat_q;

	function automatic logic [OW:0] sat_coord(input logic neg, input logic [QN-1:0] q);
		logic [OW-1:0] mag;
		logic [OW:0]   res;
		mag = q[OW-1:0];
		if (!neg) begin
			if (q[QN-1] || q[OW-1]) res = {1'b1, 1'b0, {(OW-1){1'b1}}};
			else res = {1'b0, mag};
		end else begin
			if (q[QN-1] || (q[OW-1] && |q[OW-2:0])) res = {1'b1, 1'b1, {(OW-1){1'b0}}};
			else res = {1'b0, ~mag + OW'(1)};
		end
		return res;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_z    <= CAMERA_Z_RST;
			cfg_q.focal_scale <= FOCAL_SCALE_RST;
			cfg_q.center_x    <= CENTER_X_RST;
			cfg_q.center_y    <= CENTER_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (pvp_reg_t'(cfg_index))
				REG_CAMERA_Z:    cfg_q.camera_z    <= cfg_data;
				REG_FOCAL_SCALE: cfg_q.focal_scale <= cfg_data[FSW-1:0];
				REG_CENTER_X:    cfg_q.center_x    <= cfg_data[CENW-1:0];
				REG_CENTER_Y:    cfg_q.center_y    <= cfg_data[CENW-1:0];
				default: ;
			endcase
		end
	end

	pvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.vertex_z  (vertex_z),
		.out_valid (chain_v[0]),
		.out_ready (chain_r[0]),
		.out_data  (chain_d[0])
	);

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		pvp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[k]),
			.in_ready  (chain_r[k]),
			.in_data   (chain_d[k]),
			.out_valid (chain_v[k+1]),
			.out_ready (chain_r[k+1]),
			.out_data  (chain_d[k+1])
		);
	end

	assign chain_r[NCELL] = !out_valid_q || out_ready;
	assign last           = chain_d[NCELL];
	assign res_x          = sat_coord(last.neg_x, last.q_x);
	assign res_y          = sat_coord(last.neg_y, last.q_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chain_r[NCELL]) begin
			out_valid_q <= chain_v[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_v[NCELL] && chain_r[NCELL]) begin
			screen_x_q <= res_x[OW-1:0];
			screen_y_q <= res_y[OW-1:0];
			clamped_q  <= last.clamped;
			sat_q      <= res_x[OW] || res_y[OW];
		end
	end

	assign out_valid     = out_valid_q;
	assign screen_x      = screen_x_q;
	assign screen_y      = screen_y_q;
	assign depth_clamped = clamped_q;
	assign saturated     = sat_q;

endmodule

// ===== hdl/pvp_front.sv =====
module pvp_front import pvp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  pvp_cfg_t        cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CW-1:0]   vertex_x,
	input  logic [CW-1:0]   vertex_y,
	input  logic [CW-1:0]   vertex_z,
	output logic            out_valid,
	input  logic            out_ready,
	output pvp_cell_t       out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [DW-1:0] depth;
	logic                 clamp;
	logic [DENW-1:0]      den;
	logic signed [PW:0]   prod_x, prod_y;

	logic [DENW-1:0] den_s1;
	logic [PW-1:0]   px_s1, py_s1;
	logic            clamp_s1;

	logic [CDW-1:0]  bx, by;
	logic [DENW-1:0] den_s2;
	logic [CDW-1:0]  bx_s2, by_s2;
	logic [PW-1:0]   px_s2, py_s2;
	logic            clamp_s2;

	logic [NW-1:0]   nx, ny;
	logic [DENW-1:0] den_s3;
	logic [NW-1:0]   nx_s3, ny_s3;
	logic            clamp_s3;

	logic [NW-1:0]   ax, ay;
	pvp_cell_t       cell_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// depth, clamp and the two focal products
	always_comb begin
		depth  = $signed({vertex_z[CW-1], vertex_z}) - $signed({cfg.camera_z[CW-1], cfg.camera_z});
		clamp  = depth < $signed({1'b0, DEPTH_ONE});
		den    = {(clamp ? DEPTH_ONE : depth[DUW-1:0]), {FRAC_BITS{1'b0}}};
		prod_x = $signed(vertex_x) * $signed({1'b0, cfg.focal_scale});
		prod_y = $signed(vertex_y) * $signed({1'b0, cfg.focal_scale});
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			den_s1   <= den;
			px_s1    <= prod_x[PW-1:0];
			py_s1    <= prod_y[PW-1:0];
			clamp_s1 <= clamp;
		end
	end

	// center scaled by the denominator
	assign bx = CDW'(cfg.center_x) * CDW'(den_s1);
	assign by = CDW'(cfg.center_y) * CDW'(den_s1);

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			den_s2   <= den_s1;
			bx_s2    <= bx;
			by_s2    <= by;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			clamp_s2 <= clamp_s1;
		end
	end

	// numerators, y runs downward on screen
	assign nx = {{(NW-CDW){1'b0}}, bx_s2} + {{(NW-PW){px_s2[PW-1]}}, px_s2};
	assign ny = {{(NW-CDW){1'b0}}, by_s2} - {{(NW-PW){py_s2[PW-1]}}, py_s2};

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			den_s3   <= den_s2;
			nx_s3    <= nx;
			ny_s3    <= ny;
			clamp_s3 <= clamp_s2;
		end
	end

	// sign and magnitude for the divider chain
	assign ax = nx_s3[NW-1] ? (~nx_s3 + NW'(1)) : nx_s3;
	assign ay = ny_s3[NW-1] ? (~ny_s3 + NW'(1)) : ny_s3;

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			cell_s4.neg_x   <= nx_s3[NW-1];
			cell_s4.neg_y   <= ny_s3[NW-1];
			cell_s4.clamped <= clamp_s3;
			cell_s4.rem_x   <= ax[NMW-1:0];
			cell_s4.rem_y   <= ay[NMW-1:0];
			cell_s4.dsh     <= {den_s3, {QW{1'b0}}};
			cell_s4.q_x     <= '0;
			cell_s4.q_y     <= '0;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = cell_s4;

endmodule

// ===== hdl/pvp_div_cell.sv =====
module pvp_div_cell import pvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pvp_cell_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output pvp_cell_t out_data
);

	logic      valid_q;
	pvp_cell_t data_q;
	pvp_cell_t nxt;
	logic      ge_x, ge_y;

	assign in_ready = !valid_q || out_ready;

	// one restoring step: subtract the aligned divisor when it fits
	always_comb begin
		nxt   = in_data;
		ge_x  = {{(DSW-NMW){1'b0}}, in_data.rem_x} >= in_data.dsh;
		ge_y  = {{(DSW-NMW){1'b0}}, in_data.rem_y} >= in_data.dsh;
		if (ge_x) nxt.rem_x = in_data.rem_x - in_data.dsh[NMW-1:0];
		if (ge_y) nxt.rem_y = in_data.rem_y - in_data.dsh[NMW-1:0];
		nxt.q_x = {in_data.q_x[QN-2:0], ge_x};
		nxt.q_y = {in_data.q_y[QN-2:0], ge_y};
		nxt.dsh = in_data.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== hdl/pvp_checker.sv =====
module pvp_checker import pvp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic signed [OW-1:0] screen_x,
	input logic signed [OW-1:0] screen_y,
	input logic                 depth_clamped,
	input logic                 saturated
);

	localparam logic [OW-1:0] SMAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] SMIN = {1'b1, {(OW-1){1'b0}}};

	// no result shows while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// a stalled result holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y)
			&& $stable(depth_clamped) && $stable(saturated))
		else $error("stalled result changed");

	// clipping always lands a coordinate on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> screen_x == SMAX || screen_x == SMIN
			|| screen_y == SMAX || screen_y == SMIN)
		else $error("saturated without a coordinate at a rail");

	// off the rails nothing was clipped
	a_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && screen_x != SMAX && screen_x != SMIN
			&& screen_y != SMAX && screen_y != SMIN |-> !saturated)
		else $error("saturated set with both coordinates in range");

endmodule

bind perspective_vertex_project pvp_checker u_pvp_checker (.*);
